@@ rtl/rud_pkg.sv @@
// Shared types and constants for the radial undistortion point pipeline.
// Used by rud_sqrt_pipe, rud_div_pipe and radial_undistort_point_top; no dependencies.
package rud_pkg;

   // Coordinate format
   localparam int FRAC_BITS = 4;
   localparam int COORD_W   = 16;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int OUT_W     = 18;
   localparam int COEFF_W   = 32;

   // Squared radius and coefficient product
   localparam int SQ_W    = 2 * COORD_W;
   localparam int S_W     = SQ_W + 1;
   localparam int SLO_W   = 17;
   localparam int SHI_W   = S_W - SLO_W;
   localparam int PLO_W   = COEFF_W + SLO_W;
   localparam int PHI_W   = COEFF_W + SHI_W;
   localparam int PROD_W  = COEFF_W + S_W;
   localparam int T_SHIFT = 7 + 2 * FRAC_BITS;
   localparam int T_W     = PROD_W - T_SHIFT;

   // Radicand in Q32 and the square root of 16 * radicand
   localparam int ONE_POS = 32;
   localparam int R_W     = T_W + 1;
   localparam int RAD_W   = ((R_W + 4 + 1) / 2) * 2;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int SQ_STEPS = ROOT_W;

   // Scaling division: q = ((|d| << 19) + root) / (2 * root)
   localparam int NUM_SHIFT = 19;
   localparam int NUM_BASE  = COORD_W + NUM_SHIFT;
   localparam int NUM_W     = ((NUM_BASE > ROOT_W) ? NUM_BASE : ROOT_W) + 1;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int DIV_STEPS = NUM_W;
   localparam int SUM_W     = NUM_W + 2;

   // Output range
   localparam logic signed [OUT_W-1:0] OUT_HI = 18'sh1FFFF;
   localparam logic signed [OUT_W-1:0] OUT_LO = 18'sh20000;
   localparam logic signed [SUM_W-1:0] OUT_HI_EXT = SUM_W'(OUT_HI);
   localparam logic signed [SUM_W-1:0] OUT_LO_EXT = SUM_W'(OUT_LO);

   // Register indexes
   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_COEFF    = 2'd2;

   // Per-item side data that travels alongside the arithmetic
   typedef struct packed {
      logic               invalid;
      logic               neg_x;
      logic               neg_y;
      logic [COORD_W-1:0] mag_x;
      logic [COORD_W-1:0] mag_y;
   } rud_tag_type;

endpackage

@@ rtl/radial_undistort_point_top.sv @@
// Radial undistortion of one image point per clock: top level with the register file.
// Depends on rud_pkg, rud_sqrt_pipe and rud_div_pipe.
//
// The block takes one distorted point in every clock cycle: busy is always low and an
// item is accepted at each edge with start high. Every item gives exactly one result,
// shown on the rsp_ ports for one cycle with rsp_valid high. Each item passes through 7
// front stages for offset, square, coefficient product and radicand, 28 square root
// stages at one root bit each, one stage to form the dividends, 36 divider stages at
// one quotient bit each and one output stage. Results leave in the order items came
// in, and they are never held back, since the receiver has no way to stall them.
// Write the csr_ registers only while no item is in flight; the pipeline reads them
// live.
module radial_undistort_point_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [rud_pkg::COORD_W-1:0]        req_point_x,
   input  logic [rud_pkg::COORD_W-1:0]        req_point_y,
   input  logic                               csr_wr_en,
   input  logic [1:0]                         csr_index,
   input  logic [rud_pkg::COEFF_W-1:0]        csr_wr_data,
   output logic                               rsp_valid,
   output logic signed [rud_pkg::OUT_W-1:0]   rsp_out_x,
   output logic signed [rud_pkg::OUT_W-1:0]   rsp_out_y,
   output logic                               rsp_invalid,
   output logic                               rsp_saturated
);
   import rud_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic                    sat;
   } rud_place_type;

   // Add the principal point back to the signed quotient and clamp to the output range
   function automatic rud_place_type place_coord(input logic [COORD_W-1:0] centre,
                                                 input logic [NUM_W-1:0]   quo,
                                                 input logic               neg);
      logic signed [SUM_W-1:0] c_ext;
      logic signed [SUM_W-1:0] q_ext;
      logic signed [SUM_W-1:0] sum;
      rud_place_type           res;
      c_ext = $signed(SUM_W'(centre));
      q_ext = $signed(SUM_W'(quo));
      sum   = neg ? (c_ext - q_ext) : (c_ext + q_ext);
      if (sum > OUT_HI_EXT) begin
         res.value = OUT_HI;
         res.sat   = 1'b1;
      end else if (sum < OUT_LO_EXT) begin
         res.value = OUT_LO;
         res.sat   = 1'b1;
      end else begin
         res.value = sum[OUT_W-1:0];
         res.sat   = 1'b0;
      end
      return res;
   endfunction

   // Configuration registers
   logic [COORD_W-1:0] centre_x_ff;
   logic [COORD_W-1:0] centre_y_ff;
   logic [COEFF_W-1:0] coeff_ff;
   logic [COEFF_W-1:0] kmag_ff;
   logic [COEFF_W-1:0] kmag_in;
   logic               k_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         coeff_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CENTER_X: centre_x_ff <= csr_wr_data[COORD_W-1:0];
            CSR_CENTER_Y: centre_y_ff <= csr_wr_data[COORD_W-1:0];
            CSR_COEFF:    coeff_ff    <= csr_wr_data;
            default:      ;
         endcase
      end
   end

   // Keep the coefficient magnitude registered so the multiplier sees no negation
   assign k_neg   = coeff_ff[COEFF_W-1];
   assign kmag_in = k_neg ? (~coeff_ff + COEFF_W'(1)) : coeff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmag_ff <= '0;
      end else begin
         kmag_ff <= kmag_in;
      end
   end

   assign busy = 1'b0;

   // Valid bits of the front stages
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic accept;

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Stage 1: offset from the principal point
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff;

   always_ff @(posedge clock) begin
      dx1_ff <= $signed({1'b0, req_point_x}) - $signed({1'b0, centre_x_ff});
      dy1_ff <= $signed({1'b0, req_point_y}) - $signed({1'b0, centre_y_ff});
   end

   // Stage 2: split the offsets into sign and magnitude
   rud_tag_type tag2_in, tag2_ff;
   logic [DIFF_W-1:0] nx_full, ny_full;

   assign nx_full = dx1_ff[DIFF_W-1] ? (~dx1_ff + DIFF_W'(1)) : dx1_ff;
   assign ny_full = dy1_ff[DIFF_W-1] ? (~dy1_ff + DIFF_W'(1)) : dy1_ff;

   always_comb begin
      tag2_in         = '0;
      tag2_in.neg_x   = dx1_ff[DIFF_W-1];
      tag2_in.neg_y   = dy1_ff[DIFF_W-1];
      tag2_in.mag_x   = nx_full[COORD_W-1:0];
      tag2_in.mag_y   = ny_full[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      tag2_ff <= tag2_in;
   end

   // Stage 3: square each magnitude
   logic [SQ_W-1:0] sqx3_ff, sqy3_ff;
   rud_tag_type     tag3_ff;

   always_ff @(posedge clock) begin
      sqx3_ff <= SQ_W'(tag2_ff.mag_x) * SQ_W'(tag2_ff.mag_x);
      sqy3_ff <= SQ_W'(tag2_ff.mag_y) * SQ_W'(tag2_ff.mag_y);
      tag3_ff <= tag2_ff;
   end

   // Stage 4: squared radius
   logic [S_W-1:0] s4_ff;
   rud_tag_type    tag4_ff;

   always_ff @(posedge clock) begin
      s4_ff   <= S_W'(sqx3_ff) + S_W'(sqy3_ff);
      tag4_ff <= tag3_ff;
   end

   // Stage 5: coefficient times radius squared as two partial products
   logic [PLO_W-1:0] plo5_ff;
   logic [PHI_W-1:0] phi5_ff;
   rud_tag_type      tag5_ff;

   always_ff @(posedge clock) begin
      plo5_ff <= PLO_W'(kmag_ff) * PLO_W'(s4_ff[SLO_W-1:0]);
      phi5_ff <= PHI_W'(kmag_ff) * PHI_W'(s4_ff[S_W-1:SLO_W]);
      tag5_ff <= tag4_ff;
   end

   // Stage 6: combine the partial products and drop the fraction below Q32
   logic [PROD_W-1:0] prod6;
   logic [T_W-1:0]    t6_ff;
   rud_tag_type       tag6_ff;

   assign prod6 = {phi5_ff, SLO_W'(0)} + PROD_W'(plo5_ff);

   always_ff @(posedge clock) begin
      t6_ff   <= prod6[PROD_W-1:T_SHIFT];
      tag6_ff <= tag5_ff;
   end

   // Stage 7: radicand 1 +/- t, flag it when not positive
   logic [R_W-1:0]   one_q32;
   logic [R_W-1:0]   r7;
   logic             bad7;
   logic [RAD_W-1:0] rad7_ff;
   rud_tag_type      tag7_in, tag7_ff;

   assign one_q32 = R_W'(1) << ONE_POS;
   assign r7      = k_neg ? (one_q32 - R_W'(t6_ff)) : (one_q32 + R_W'(t6_ff));
   assign bad7    = k_neg & (t6_ff[T_W-1:ONE_POS] != '0);

   always_comb begin
      tag7_in         = tag6_ff;
      tag7_in.invalid = bad7;
   end

   always_ff @(posedge clock) begin
      rad7_ff <= RAD_W'({r7, 4'b0000});
      tag7_ff <= tag7_in;
   end

   // Square root of sixteen times the radicand
   logic              vsq;
   logic [ROOT_W-1:0] root_sq;
   rud_tag_type       tag_sq;

   rud_sqrt_pipe u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (v7_ff),
      .rad_i  (rad7_ff),
      .tag_i  (tag7_ff),
      .vld_o  (vsq),
      .root_o (root_sq),
      .tag_o  (tag_sq)
   );

   // Stage 8: dividends with the rounding term, divisor twice the root
   logic [NUM_W-1:0] numx8_ff, numy8_ff;
   logic [DEN_W-1:0] den8_ff;
   rud_tag_type      tag8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= vsq;
      end
   end

   always_ff @(posedge clock) begin
      numx8_ff <= NUM_W'({tag_sq.mag_x, NUM_SHIFT'(0)}) + NUM_W'(root_sq);
      numy8_ff <= NUM_W'({tag_sq.mag_y, NUM_SHIFT'(0)}) + NUM_W'(root_sq);
      den8_ff  <= {root_sq, 1'b0};
      tag8_ff  <= tag_sq;
   end

   // Divide both offsets by the shared divisor
   logic             vdv;
   logic [NUM_W-1:0] quo_x, quo_y;
   rud_tag_type      tag_dv;

   rud_div_pipe u_div (
      .clock   (clock),
      .reset   (reset),
      .vld_i   (v8_ff),
      .num_x_i (numx8_ff),
      .num_y_i (numy8_ff),
      .den_i   (den8_ff),
      .tag_i   (tag8_ff),
      .vld_o   (vdv),
      .quo_x_o (quo_x),
      .quo_y_o (quo_y),
      .tag_o   (tag_dv)
   );

   // Output stage: place, clamp, and zero invalid items
   rud_place_type pl_x, pl_y;

   assign pl_x = place_coord(centre_x_ff, quo_x, tag_dv.neg_x);
   assign pl_y = place_coord(centre_y_ff, quo_y, tag_dv.neg_y);

   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] out_x_ff, out_y_ff;
   logic                    invalid_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vdv;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_dv.invalid) begin
         out_x_ff   <= '0;
         out_y_ff   <= '0;
         invalid_ff <= 1'b1;
         sat_ff     <= 1'b0;
      end else begin
         out_x_ff   <= pl_x.value;
         out_y_ff   <= pl_y.value;
         invalid_ff <= 1'b0;
         sat_ff     <= pl_x.sat | pl_y.sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_invalid   = invalid_ff;
   assign rsp_saturated = sat_ff;

endmodule

@@ rtl/rud_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on rud_pkg for widths and the side-data struct.
module rud_sqrt_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        vld_i,
   input  logic [rud_pkg::RAD_W-1:0]   rad_i,
   input  rud_pkg::rud_tag_type        tag_i,
   output logic                        vld_o,
   output logic [rud_pkg::ROOT_W-1:0]  root_o,
   output rud_pkg::rud_tag_type        tag_o
);
   import rud_pkg::*;

   logic              vld_ff  [SQ_STEPS];
   logic [RAD_W-1:0]  rad_ff  [SQ_STEPS];
   logic [REM_W-1:0]  rem_ff  [SQ_STEPS];
   logic [ROOT_W-1:0] root_ff [SQ_STEPS];
   rud_tag_type       tag_ff  [SQ_STEPS];

   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
      logic              vld_src;
      logic [RAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      rud_tag_type       tag_src;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  sub;
      logic              fits;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W-1:0]  rad_in;

      // Pick up the stage before, or the inputs at the head
      if (g == 0) begin : g_head
         assign vld_src  = vld_i;
         assign rad_src  = rad_i;
         assign rem_src  = '0;
         assign root_src = '0;
         assign tag_src  = tag_i;
      end else begin : g_body
         assign vld_src  = vld_ff[g-1];
         assign rad_src  = rad_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign tag_src  = tag_ff[g-1];
      end

      // Bring down two radicand bits and try the next root bit
      assign trial   = {rem_src, rad_src[RAD_W-1 -: 2]};
      assign sub     = (REM_W + 2)'({root_src, 2'b01});
      assign fits    = (trial >= sub);
      assign rem_in  = fits ? REM_W'(trial - sub) : REM_W'(trial);
      assign root_in = {root_src[ROOT_W-2:0], fits};
      assign rad_in  = {rad_src[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= rad_in;
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         tag_ff[g]  <= tag_src;
      end
   end

   assign vld_o  = vld_ff[SQ_STEPS-1];
   assign root_o = root_ff[SQ_STEPS-1];
   assign tag_o  = tag_ff[SQ_STEPS-1];

endmodule

@@ rtl/rud_div_pipe.sv @@
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit a stage.
// Depends on rud_pkg for widths and the side-data struct.
module rud_div_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        vld_i,
   input  logic [rud_pkg::NUM_W-1:0]   num_x_i,
   input  logic [rud_pkg::NUM_W-1:0]   num_y_i,
   input  logic [rud_pkg::DEN_W-1:0]   den_i,
   input  rud_pkg::rud_tag_type        tag_i,
   output logic                        vld_o,
   output logic [rud_pkg::NUM_W-1:0]   quo_x_o,
   output logic [rud_pkg::NUM_W-1:0]   quo_y_o,
   output rud_pkg::rud_tag_type        tag_o
);
   import rud_pkg::*;

   logic             vld_ff   [DIV_STEPS];
   logic [NUM_W-1:0] num_x_ff [DIV_STEPS];
   logic [NUM_W-1:0] num_y_ff [DIV_STEPS];
   logic [DEN_W-1:0] rem_x_ff [DIV_STEPS];
   logic [DEN_W-1:0] rem_y_ff [DIV_STEPS];
   logic [DEN_W-1:0] den_ff   [DIV_STEPS];
   rud_tag_type      tag_ff   [DIV_STEPS];

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      logic             vld_src;
      logic [NUM_W-1:0] num_x_src;
      logic [NUM_W-1:0] num_y_src;
      logic [DEN_W-1:0] rem_x_src;
      logic [DEN_W-1:0] rem_y_src;
      logic [DEN_W-1:0] den_src;
      rud_tag_type      tag_src;
      logic [DEN_W:0]   den_ext;
      logic [DEN_W:0]   trial_x;
      logic [DEN_W:0]   trial_y;
      logic             fit_x;
      logic             fit_y;
      logic [DEN_W-1:0] rem_x_in;
      logic [DEN_W-1:0] rem_y_in;
      logic [NUM_W-1:0] num_x_in;
      logic [NUM_W-1:0] num_y_in;

      // Pick up the stage before, or the inputs at the head
      if (g == 0) begin : g_head
         assign vld_src   = vld_i;
         assign num_x_src = num_x_i;
         assign num_y_src = num_y_i;
         assign rem_x_src = '0;
         assign rem_y_src = '0;
         assign den_src   = den_i;
         assign tag_src   = tag_i;
      end else begin : g_body
         assign vld_src   = vld_ff[g-1];
         assign num_x_src = num_x_ff[g-1];
         assign num_y_src = num_y_ff[g-1];
         assign rem_x_src = rem_x_ff[g-1];
         assign rem_y_src = rem_y_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign tag_src   = tag_ff[g-1];
      end

      // Shift in the next dividend bit, subtract where the divisor fits,
      // and shift the quotient bit into the vacated end of the dividend
      assign den_ext  = {1'b0, den_src};
      assign trial_x  = {rem_x_src, num_x_src[NUM_W-1]};
      assign trial_y  = {rem_y_src, num_y_src[NUM_W-1]};
      assign fit_x    = (trial_x >= den_ext);
      assign fit_y    = (trial_y >= den_ext);
      assign rem_x_in = fit_x ? DEN_W'(trial_x - den_ext) : DEN_W'(trial_x);
      assign rem_y_in = fit_y ? DEN_W'(trial_y - den_ext) : DEN_W'(trial_y);
      assign num_x_in = {num_x_src[NUM_W-2:0], fit_x};
      assign num_y_in = {num_y_src[NUM_W-2:0], fit_y};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         num_x_ff[g] <= num_x_in;
         num_y_ff[g] <= num_y_in;
         rem_x_ff[g] <= rem_x_in;
         rem_y_ff[g] <= rem_y_in;
         den_ff[g]   <= den_src;
         tag_ff[g]   <= tag_src;
      end
   end

   assign vld_o   = vld_ff[DIV_STEPS-1];
   assign quo_x_o = num_x_ff[DIV_STEPS-1];
   assign quo_y_o = num_y_ff[DIV_STEPS-1];
   assign tag_o   = tag_ff[DIV_STEPS-1];

endmodule
